// ===== hw/rtl/sqi_pkg.sv =====
package sqi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned QW    = 17;
  localparam int unsigned ProdW = DataW + FracW;
  localparam logic [QW-1:0] QOne = 17'h10000;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_Q_MUL,
    S_Q_RDLO,
    S_Q_RDHI,
    S_Q_MUL2,
    S_Q_ADD,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_POS_PREV,
    RD_IDX,
    RD_IDX_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_KEEP,
    RES_ZERO,
    RES_RDATA,
    RES_INTERP
  } res_op_e;

  typedef struct packed {
    logic    take_in;
    logic    cnt_clear;
    logic    cnt_inc;
    logic    pos_load;
    logic    pos_dec;
    logic    mem_we;
    logic    wr_rdata;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    mul_pos;
    logic    mul_diff;
    logic    lo_load;
    res_op_e res_op;
    logic    st_load;
    status_e st_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cnt_zero;
    logic       cnt_full;
    logic       pos_zero;
    logic       rd_gt;
    logic       interp_skip;
  } stat_t;

endpackage

// ===== hw/rtl/sqi_in_if.sv =====
interface sqi_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic signed [31:0]  sample_value;
  logic [16:0]         quantile_fraction;

  modport source (output valid, mode, sample_value, quantile_fraction, input ready);
  modport sink   (input valid, mode, sample_value, quantile_fraction, output ready);
endinterface

// ===== hw/rtl/sqi_out_if.sv =====
interface sqi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== hw/rtl/sqi_dp.sv =====
module sqi_dp #(
  parameter int unsigned MaxSamples = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  mode_i,
  input  logic [sqi_pkg::DataW-1:0]   sample_value_i,
  input  logic [sqi_pkg::QW-1:0]      quantile_fraction_i,
  input  sqi_pkg::cmd_t               cmd_i,
  output sqi_pkg::stat_t              stat_o,
  output logic [sqi_pkg::DataW-1:0]   result_value_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned AW = $clog2(MaxSamples);
  localparam int unsigned CW = $clog2(MaxSamples + 1);
  localparam int unsigned PW = sqi_pkg::QW + CW;

  logic [sqi_pkg::DataW-1:0] mem [MaxSamples];

  logic [1:0]                mode_q;
  logic [sqi_pkg::DataW-1:0] sample_q;
  logic [sqi_pkg::QW-1:0]    frac_in_q;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             pos_q;
  logic [sqi_pkg::DataW-1:0] rdata_q;
  logic [PW-1:0]             p_q;
  logic [sqi_pkg::DataW-1:0] lo_q;
  logic [sqi_pkg::ProdW-1:0] prod_q;
  logic [sqi_pkg::DataW-1:0] res_q;
  sqi_pkg::status_e          st_q;
  logic [sqi_pkg::DataW-1:0] out_value_q;
  logic [1:0]                out_status_q;

  logic [sqi_pkg::QW-1:0]    q_sat;
  logic [CW-1:0]             cnt_m1;
  logic [AW-1:0]             idx;
  logic [sqi_pkg::FracW-1:0] frac;
  logic [AW-1:0]             raddr;
  logic [sqi_pkg::DataW-1:0] wdata;
  logic [sqi_pkg::DataW-1:0] diff;

  assign q_sat  = (frac_in_q > sqi_pkg::QOne) ? sqi_pkg::QOne : frac_in_q;
  assign cnt_m1 = cnt_q - CW'(1);
  assign idx    = p_q[sqi_pkg::FracW +: AW];
  assign frac   = p_q[sqi_pkg::FracW-1:0];
  // store is sorted, so hi - lo is non-negative and fits 32 unsigned bits
  assign diff   = rdata_q - lo_q;
  assign wdata  = cmd_i.wr_rdata ? rdata_q : sample_q;

  always_comb begin
    case (cmd_i.rd_sel)
      sqi_pkg::RD_POS_PREV: raddr = pos_q - AW'(1);
      sqi_pkg::RD_IDX:      raddr = idx;
      sqi_pkg::RD_IDX_NEXT: raddr = idx + AW'(1);
      default:              raddr = idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[pos_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clear) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      mode_q    <= mode_i;
      sample_q  <= sample_value_i;
      frac_in_q <= quantile_fraction_i;
    end
    if (cmd_i.pos_load) begin
      pos_q <= cnt_q[AW-1:0];
    end else if (cmd_i.pos_dec) begin
      pos_q <= pos_q - AW'(1);
    end
    if (cmd_i.mul_pos) begin
      p_q <= PW'(q_sat) * PW'(cnt_m1);
    end
    if (cmd_i.lo_load) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.mul_diff) begin
      prod_q <= sqi_pkg::ProdW'(diff) * sqi_pkg::ProdW'(frac);
    end
    case (cmd_i.res_op)
      sqi_pkg::RES_ZERO:   res_q <= '0;
      sqi_pkg::RES_RDATA:  res_q <= rdata_q;
      sqi_pkg::RES_INTERP: res_q <= lo_q + prod_q[sqi_pkg::ProdW-1:sqi_pkg::FracW];
      default:             res_q <= res_q;
    endcase
    if (cmd_i.st_load) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_q;
      out_status_q <= st_q;
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.cnt_full    = (cnt_q == CW'(MaxSamples));
  assign stat_o.pos_zero    = (pos_q == '0);
  assign stat_o.rd_gt       = ($signed(rdata_q) > $signed(sample_q));
  assign stat_o.interp_skip = (frac == '0) || ((CW'(idx) + CW'(1)) >= cnt_q);

  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

endmodule

// ===== hw/rtl/sqi_ctrl.sv =====
module sqi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sqi_pkg::stat_t stat_i,
  output sqi_pkg::cmd_t  cmd_o
);

  sqi_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;

  assign in_ready_o = (state_q == sqi_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sqi_pkg::S_IDLE: begin
        if (accept) state_d = sqi_pkg::S_DECODE;
      end
      sqi_pkg::S_DECODE: begin
        if (stat_i.mode == sqi_pkg::MODE_LOAD && !stat_i.cnt_full) begin
          state_d = sqi_pkg::S_INS_RD;
        end else if (stat_i.mode == sqi_pkg::MODE_QUERY && !stat_i.cnt_zero) begin
          state_d = sqi_pkg::S_Q_MUL;
        end else begin
          state_d = sqi_pkg::S_RESP;
        end
      end
      sqi_pkg::S_INS_RD: begin
        state_d = stat_i.pos_zero ? sqi_pkg::S_RESP : sqi_pkg::S_INS_CMP;
      end
      sqi_pkg::S_INS_CMP: begin
        state_d = stat_i.rd_gt ? sqi_pkg::S_INS_RD : sqi_pkg::S_RESP;
      end
      sqi_pkg::S_Q_MUL:  state_d = sqi_pkg::S_Q_RDLO;
      sqi_pkg::S_Q_RDLO: state_d = sqi_pkg::S_Q_RDHI;
      sqi_pkg::S_Q_RDHI: begin
        state_d = stat_i.interp_skip ? sqi_pkg::S_RESP : sqi_pkg::S_Q_MUL2;
      end
      sqi_pkg::S_Q_MUL2: state_d = sqi_pkg::S_Q_ADD;
      sqi_pkg::S_Q_ADD:  state_d = sqi_pkg::S_RESP;
      sqi_pkg::S_RESP: begin
        if (out_free) state_d = sqi_pkg::S_IDLE;
      end
      default: state_d = sqi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = sqi_pkg::RD_IDX;
    cmd_o.res_op  = sqi_pkg::RES_KEEP;
    cmd_o.st_code = sqi_pkg::ST_OK;
    case (state_q)
      sqi_pkg::S_IDLE: begin
        cmd_o.take_in = accept;
      end
      sqi_pkg::S_DECODE: begin
        cmd_o.st_load = 1'b1;
        cmd_o.res_op  = sqi_pkg::RES_ZERO;
        case (stat_i.mode)
          sqi_pkg::MODE_LOAD: begin
            if (stat_i.cnt_full) begin
              cmd_o.st_code = sqi_pkg::ST_FULL;
            end else begin
              cmd_o.pos_load = 1'b1;
            end
          end
          sqi_pkg::MODE_QUERY: begin
            if (stat_i.cnt_zero) begin
              cmd_o.st_code = sqi_pkg::ST_EMPTY;
            end
          end
          sqi_pkg::MODE_CLEAR: begin
            cmd_o.cnt_clear = 1'b1;
          end
          default: begin
            cmd_o.st_code = sqi_pkg::ST_OK;
          end
        endcase
      end
      sqi_pkg::S_INS_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.mem_we  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sqi_pkg::RD_POS_PREV;
        end
      end
      sqi_pkg::S_INS_CMP: begin
        // larger neighbor moves up one slot, else the new sample lands here
        cmd_o.mem_we = 1'b1;
        if (stat_i.rd_gt) begin
          cmd_o.wr_rdata = 1'b1;
          cmd_o.pos_dec  = 1'b1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      sqi_pkg::S_Q_MUL: begin
        cmd_o.mul_pos = 1'b1;
      end
      sqi_pkg::S_Q_RDLO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sqi_pkg::RD_IDX;
      end
      sqi_pkg::S_Q_RDHI: begin
        cmd_o.lo_load = 1'b1;
        if (stat_i.interp_skip) begin
          cmd_o.res_op = sqi_pkg::RES_RDATA;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sqi_pkg::RD_IDX_NEXT;
        end
      end
      sqi_pkg::S_Q_MUL2: begin
        cmd_o.mul_diff = 1'b1;
      end
      sqi_pkg::S_Q_ADD: begin
        cmd_o.res_op = sqi_pkg::RES_INTERP;
      end
      sqi_pkg::S_RESP: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o.take_in = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/sorted_quantile_interpolator.sv =====
// Channel  Dir  Payload                                      Handshake
// in_i     in   mode, sample_value, quantile_fraction        valid/ready
// out_o    out  result_value, status                         valid/ready
//
// One transaction is worked at a time; every input gives exactly one result.
// Clear, ignored mode, full store and empty query go from decode straight to the response.
// Query: two multiplies, the second skipped when the fraction lands on a sample.
// Load: every stored sample larger than the new one moves up one slot;
// each shifted sample costs a read and a write of the memory.
// Reset clears the count and control only. A stalled result holds in the
// output register while the next transaction is accepted and worked.
module sorted_quantile_interpolator #(
  parameter int unsigned MaxSamples = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sqi_in_if.sink          in_i,
  sqi_out_if.source       out_o
);

  sqi_pkg::cmd_t  cmd;
  sqi_pkg::stat_t stat;
  logic [sqi_pkg::DataW-1:0] result_value;

  sqi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sqi_dp #(
    .MaxSamples (MaxSamples)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .mode_i              (in_i.mode),
    .sample_value_i      (in_i.sample_value),
    .quantile_fraction_i (in_i.quantile_fraction),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .result_value_o      (result_value),
    .status_o            (out_o.status)
  );

  assign out_o.result_value = $signed(result_value);

endmodule

// ===== hw/rtl/sqi_checker.sv =====
module sqi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_value_i,
  input logic [1:0]  status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_value_i) && $stable(status_i))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transaction taken while one is in work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == sqi_pkg::ST_EMPTY || status_i == sqi_pkg::ST_FULL)
      |-> result_value_i == '0)
    else $error("error status with nonzero result");

endmodule

bind sorted_quantile_interpolator sqi_checker u_sqi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .status_i       (out_o.status)
);

// ===== sim/sqi_result_checker.sv =====
module sqi_result_checker #(
  parameter int unsigned MaxSamples = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqi_in_if           in_mon,
  sqi_out_if          out_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned dropped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [sqi_pkg::DataW-1:0] value;
    sqi_pkg::status_e                 status;
  } answer_t;

  logic signed [sqi_pkg::DataW-1:0] sorted_q [MaxSamples];
  int unsigned                      stored = 0;
  answer_t                          answers_q [$];

  task automatic report(input string what);
    $display("%0t ns sqi_result_checker: %s", $realtime, what);
    mismatches_o++;
  endtask

  // Insertion sort, equal samples land after the existing ones.
  function automatic sqi_pkg::status_e store_sample(
      input logic signed [sqi_pkg::DataW-1:0] v);
    int unsigned pos;
    if (stored >= MaxSamples) return sqi_pkg::ST_FULL;
    pos = stored;
    while (pos > 0 && sorted_q[pos-1] > v) begin
      sorted_q[pos] = sorted_q[pos-1];
      pos--;
    end
    sorted_q[pos] = v;
    stored++;
    return sqi_pkg::ST_OK;
  endfunction

  function automatic logic signed [sqi_pkg::DataW-1:0] quantile_at(
      input logic [sqi_pkg::QW-1:0] q);
    logic [sqi_pkg::QW-1:0]    qs;
    logic [31:0]               p;
    int unsigned               idx;
    logic [sqi_pkg::FracW-1:0] frac;
    logic signed [63:0]        lo, hi;
    logic [63:0]               span, part, sum;
    qs   = (q > sqi_pkg::QOne) ? sqi_pkg::QOne : q;
    p    = 32'(qs) * 32'(stored - 1);
    idx  = p >> sqi_pkg::FracW;
    frac = p[sqi_pkg::FracW-1:0];
    if (idx >= stored) idx = stored - 1;
    lo = sorted_q[idx];
    if (frac == '0 || idx + 1 >= stored) return lo[sqi_pkg::DataW-1:0];
    hi = sorted_q[idx+1];
    span = hi - lo;
    // span is never negative, so the unsigned shift is the floor
    part = (span * 64'(frac)) >> sqi_pkg::FracW;
    sum  = lo + part;
    return sum[sqi_pkg::DataW-1:0];
  endfunction

  function automatic answer_t predict(input logic [1:0] mode,
                                      input logic signed [sqi_pkg::DataW-1:0] sample,
                                      input logic [sqi_pkg::QW-1:0] frac);
    answer_t a;
    a.value  = '0;
    a.status = sqi_pkg::ST_OK;
    case (mode)
      sqi_pkg::MODE_LOAD: begin
        a.status = store_sample(sample);
        if (a.status == sqi_pkg::ST_FULL) dropped_o++;
      end
      sqi_pkg::MODE_QUERY: begin
        if (stored == 0) a.status = sqi_pkg::ST_EMPTY;
        else a.value = quantile_at(frac);
      end
      sqi_pkg::MODE_CLEAR: stored = 0;
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        got.value  = out_mon.result_value;
        got.status = sqi_pkg::status_e'(out_mon.status);
        if (answers_q.size() == 0) begin
          report($sformatf("result %0d status %0d with no transaction outstanding",
                           got.value, got.status));
        end else begin
          want = answers_q.pop_front();
          checked_o++;
          if (got.value !== want.value)
            report($sformatf("result_value %0d, predicted %0d", got.value, want.value));
          if (got.status !== want.status)
            report($sformatf("status %0d, predicted %0d", got.status, want.status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        answers_q.push_back(predict(in_mon.mode, in_mon.sample_value,
                                    in_mon.quantile_fraction));
      pending_o = answers_q.size();
    end
  end

endmodule

// ===== sim/sorted_quantile_interpolator_tb.sv =====
module sorted_quantile_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSamples  = 256;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned PhaseItems  = 12;
  localparam logic [1:0]  ModeSpare   = 2'd3;
  localparam logic signed [sqi_pkg::DataW-1:0] SMin = 32'sh8000_0000;
  localparam logic signed [sqi_pkg::DataW-1:0] SMax = 32'sh7fff_ffff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sqi_in_if  in_if ();
  sqi_out_if out_if ();

  int unsigned mismatches, pending, checked, dropped;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_kicks = 0;
  int unsigned sent = 0, n_load = 0, n_query = 0, n_clear = 0, n_spare = 0;
  int unsigned cycles = 0;

  always #10 clk_i = ~clk_i;

  sorted_quantile_interpolator #(.MaxSamples(MaxSamples)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sqi_result_checker #(.MaxSamples(MaxSamples)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .dropped_o    (dropped)
  );

  // Result side: random stalls plus an occasional long hold-off.
  initial begin
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_kicks != hold_seen) begin
        hold_seen = hold_kicks;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic logic signed [sqi_pkg::DataW-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(16)) - 8;
      2: begin
        case ($urandom_range(5))
          0: return SMin;
          1: return SMax;
          2: return SMin + 1;
          3: return SMax - 1;
          4: return 0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic logic [sqi_pkg::QW-1:0] rand_frac();
    case ($urandom_range(7))
      0: return '0;
      1: return sqi_pkg::QOne;
      2: return sqi_pkg::QW'($urandom_range(131071));
      3: return {1'b0, 4'($urandom_range(15)), 12'h000};
      default: return sqi_pkg::QW'($urandom_range(65536));
    endcase
  endfunction

  // One transaction; valid stays high when the next one follows directly.
  task automatic offer(input logic [1:0] m, input logic signed [sqi_pkg::DataW-1:0] v,
                       input logic [sqi_pkg::QW-1:0] q);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.mode              <= m;
    in_if.sample_value      <= v;
    in_if.quantile_fraction <= q;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    case (m)
      sqi_pkg::MODE_LOAD:  n_load++;
      sqi_pkg::MODE_QUERY: n_query++;
      sqi_pkg::MODE_CLEAR: n_clear++;
      default:             n_spare++;
    endcase
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Typical use: usually a clear, a handful of loads, a few queries, some noise.
  task automatic burst();
    int unsigned n_ld, n_qy;
    if ($urandom_range(9) < 7) offer(sqi_pkg::MODE_CLEAR, rand_sample(), rand_frac());
    n_ld = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    n_qy = $urandom_range(1, 6);
    repeat (n_ld) offer(sqi_pkg::MODE_LOAD, rand_sample(), rand_frac());
    repeat (n_qy) begin
      if ($urandom_range(9) == 0) offer(ModeSpare, rand_sample(), rand_frac());
      else offer(sqi_pkg::MODE_QUERY, rand_sample(), rand_frac());
    end
  endtask

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sorted_quantile_interpolator_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    in_if.valid             = 1'b0;
    in_if.mode              = sqi_pkg::MODE_LOAD;
    in_if.sample_value      = '0;
    in_if.quantile_fraction = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty set, extremes, saturation, ties, floor rounding
    offer(sqi_pkg::MODE_QUERY, 0, '0);
    offer(sqi_pkg::MODE_QUERY, 0, sqi_pkg::QOne);
    offer(ModeSpare, SMax, 17'h1ffff);
    offer(sqi_pkg::MODE_CLEAR, SMin, '0);
    offer(sqi_pkg::MODE_LOAD, SMax, '0);
    offer(sqi_pkg::MODE_LOAD, SMin, '0);
    offer(sqi_pkg::MODE_QUERY, 0, '0);
    offer(sqi_pkg::MODE_QUERY, 0, sqi_pkg::QOne);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd32768);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd1);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd65535);
    offer(sqi_pkg::MODE_QUERY, 0, 17'h1ffff);
    offer(sqi_pkg::MODE_LOAD, 0, '0);
    offer(sqi_pkg::MODE_LOAD, 0, '0);
    offer(sqi_pkg::MODE_LOAD, -3, '0);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd16384);
    offer(sqi_pkg::MODE_CLEAR, 0, '0);
    offer(sqi_pkg::MODE_LOAD, -2, '0);
    offer(sqi_pkg::MODE_LOAD, -3, '0);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd1);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd32768);
    offer(sqi_pkg::MODE_LOAD, -1, '0);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd49151);
    offer(sqi_pkg::MODE_CLEAR, 0, '0);
    offer(sqi_pkg::MODE_QUERY, 0, 17'd40000);

    // fill the store to capacity, overflow it, then query the full set
    offer(sqi_pkg::MODE_CLEAR, 0, '0);
    repeat (MaxSamples) offer(sqi_pkg::MODE_LOAD, rand_sample(), rand_frac());
    repeat (3) offer(sqi_pkg::MODE_LOAD, rand_sample(), rand_frac());
    offer(sqi_pkg::MODE_QUERY, 0, '0);
    offer(sqi_pkg::MODE_QUERY, 0, sqi_pkg::QOne);
    offer(sqi_pkg::MODE_QUERY, 0, 17'h1ffff);
    repeat (6) offer(sqi_pkg::MODE_QUERY, rand_sample(), rand_frac());

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      if (ph == 2) begin
        // long hold-off on results while inputs keep coming, then drain
        hold_kicks++;
        repeat (4) burst();
        go_quiet();
        wait (pending == 0);
      end
      phase_start = sent;
      while (sent - phase_start < PhaseItems) burst();
    end

    go_quiet();
    wait (pending == 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d transactions: %0d loads, %0d queries, %0d clears, %0d spare mode",
             sent, n_load, n_query, n_clear, n_spare);
    $display("%0d results checked, %0d loads refused by a full store", checked, dropped);
    if (mismatches == 0) begin
      $display("sorted_quantile_interpolator_tb: done, clean");
    end else begin
      $display("sorted_quantile_interpolator_tb: done, errors");
    end
    $finish;
  end

endmodule
